### sv/esc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg: shared types, constants and functions
// Register codes, product and divider helpers for the compensation pipeline.
// ----------------------------------------------------------------------------
package esc_pkg;

	// register indexes of the configuration channel
	typedef enum logic [2:0] {
		REG_TEMP_CAL  = 3'd0,
		REG_PRES_LO   = 3'd1,
		REG_PRES_HI   = 3'd2,
		REG_PRES_P9   = 3'd3,
		REG_HUM_CAL   = 3'd4
	} cfg_reg_t;

	localparam int DIV_STAGES = 16;
	localparam int DIV_STEPS  = 64 / DIV_STAGES;

	localparam logic [63:0] HUM_MAX = 64'd419430400;
	localparam logic [16:0] PRES_MAX = 17'd131071;

	// partial products of a 64 x 64 multiply, kept modulo 2^64
	typedef struct packed {
		logic [63:0] ll;
		logic [31:0] lh;
		logic [31:0] hl;
	} mul_pp_t;

	// one divider stage: remainder, dividend/quotient shift word, divisor magnitude, sign and zero-divisor flags
	typedef struct packed {
		logic [30:0] rem;
		logic [63:0] dq;
		logic [30:0] mb;
		logic        neg;
		logic        dz;
	} div_st_t;

	// results carried next to the divider
	typedef struct packed {
		logic [15:0] tout;
		logic [16:0] hout;
	} side_t;

	function automatic mul_pp_t mul_pp(input logic [63:0] a, input logic [63:0] b);
		mul_pp_t r;
		r.ll = a[31:0] * b[31:0];
		r.lh = a[31:0] * b[63:32];
		r.hl = a[63:32] * b[31:0];
		return r;
	endfunction

	function automatic logic [63:0] mul_fin(input mul_pp_t p);
		logic [31:0] x;
		x = p.lh + p.hl;
		return p.ll + {x, 32'b0};
	endfunction

	// restoring division, DIV_STEPS quotient bits
	function automatic div_st_t div_steps(input div_st_t s);
		div_st_t r;
		logic [31:0] t;
		r = s;
		for (int i = 0; i < DIV_STEPS; i++) begin
			t = {r.rem, r.dq[63]};
			r.dq = {r.dq[62:0], 1'b0};
			if (t >= {1'b0, r.mb}) begin
				t = t - {1'b0, r.mb};
				r.dq[0] = 1'b1;
			end
			r.rem = t[30:0];
		end
		return r;
	endfunction

endpackage

### sv/environment_sensor_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// environment_sensor_compensation: integer sensor compensation pipeline
// Raw temperature, pressure and humidity to calibrated values.
// ----------------------------------------------------------------------------
// usage:
//   calibration words are written on the cfg channel (cfg_index selects the
//   register, cfg_data holds the value) while no word is in flight; cfg_ready
//   is always high and indexes past the humidity word are dropped
//   a raw triple enters on s_tvalid/s_tready, one compensated triple leaves on
//   m_tvalid/m_tready for every word taken
// throughput: one word per cycle, the pipeline is fully stalled only when
//   the output register and its skid stage are both full
// path: the pressure chain is the longest from acceptance to m_tvalid; its
//   signed 64-bit division runs 16 stages at 4 bits each, followed by the
//   second-order pressure correction
// reset: arst_n clears every valid bit, the output and skid flags and all
//   calibration words (zero calibration gives a zero pressure divisor)
// stall: when m_tready is low the waiting result holds, the next result
//   goes to the skid stage and s_tready drops until the skid drains
// ----------------------------------------------------------------------------
module environment_sensor_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // raw_temperature[19:0], raw_pressure[39:20],
	                               // raw_humidity[55:40]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // temperature_centi[15:0], pressure_pa[32:16],
	                               // humidity_q10[49:33], zero fill above
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int LAST = 37;

	// calibration registers
	logic [47:0] temp_cal_q;
	logic [63:0] pres_lo_q;
	logic [63:0] pres_hi_q;
	logic [15:0] p9_q;
	logic [63:0] hum_cal_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q <= '0;
			pres_lo_q  <= '0;
			pres_hi_q  <= '0;
			p9_q       <= '0;
			hum_cal_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				esc_pkg::REG_TEMP_CAL: temp_cal_q <= cfg_data[47:0];
				esc_pkg::REG_PRES_LO:  pres_lo_q  <= cfg_data;
				esc_pkg::REG_PRES_HI:  pres_hi_q  <= cfg_data;
				esc_pkg::REG_PRES_P9:  p9_q       <= cfg_data[15:0];
				esc_pkg::REG_HUM_CAL:  hum_cal_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// calibration fields
	logic        [15:0] t1;
	logic signed [15:0] t2, t3;
	logic        [15:0] p1;
	logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
	logic        [7:0]  h1, h3;
	logic signed [15:0] h2;
	logic signed [11:0] h4, h5;
	logic signed [7:0]  h6;

	assign t1 = temp_cal_q[15:0];
	assign t2 = temp_cal_q[31:16];
	assign t3 = temp_cal_q[47:32];
	assign p1 = pres_lo_q[15:0];
	assign p2 = pres_lo_q[31:16];
	assign p3 = pres_lo_q[47:32];
	assign p4 = pres_lo_q[63:48];
	assign p5 = pres_hi_q[15:0];
	assign p6 = pres_hi_q[31:16];
	assign p7 = pres_hi_q[47:32];
	assign p8 = pres_hi_q[63:48];
	assign p9 = p9_q;
	assign h1 = hum_cal_q[7:0];
	assign h2 = hum_cal_q[23:8];
	assign h3 = hum_cal_q[31:24];
	assign h4 = hum_cal_q[43:32];
	assign h5 = hum_cal_q[55:44];
	assign h6 = hum_cal_q[63:56];

	// flow control: the whole pipeline moves unless the skid stage is full
	logic              sk_q, ov_q;
	logic              en;
	logic [LAST:1]     vld_q;

	assign en       = !sk_q;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAST-1:1], s_tvalid};
		end
	end

	// input fields
	logic [19:0] rt, rp;
	logic [15:0] rh;
	assign rt = s_tdata[19:0];
	assign rp = s_tdata[39:20];
	assign rh = s_tdata[55:40];

	// stage registers
	logic signed [17:0] x1_s1;
	logic signed [16:0] d_s1;
	logic [19:0]        rp_s1, rp_s2, rp_s3, rp_s4, rp_s5, rp_s6, rp_s7, rp_s8, rp_s9, rp_s10;
	logic [15:0]        rh_s1, rh_s2, rh_s3, rh_s4, rh_s5, rh_s6;
	logic signed [33:0] ma_s2, dd_s2;
	logic signed [22:0] at_s3;
	logic signed [37:0] eb_s3;
	logic signed [24:0] tf_s4;
	logic [15:0]        tout_s5, tout_s6, tout_s7, tout_s8, tout_s9, tout_s10;
	logic [15:0]        tout_s11, tout_s12, tout_s13, tout_s14;
	logic signed [25:0] pa_s5, hv_s5;
	logic signed [51:0] aa_s6;
	logic signed [41:0] ap5_s6, ap2_s6, ap5_s7, ap2_s7, ap5_s8, ap2_s8;
	logic signed [37:0] m5_s6;
	logic signed [33:0] m6_s6;
	logic signed [34:0] m3_s6;
	esc_pkg::mul_pp_t   pp6_s7, pp3_s7;
	logic signed [23:0] ha_s7, ha_s8, ha_s9, ha_s10, ha_s11;
	logic signed [23:0] u_s7;
	logic signed [24:0] w_s7;
	logic [63:0]        b6_s8, b3_s8;
	logic signed [48:0] uw_s8;
	logic [63:0]        b_s9, ac_s9, b_s10;
	logic signed [39:0] hb0_s9;
	esc_pkg::mul_pp_t   ppc_s10;
	logic signed [55:0] m2_s10;
	logic signed [30:0] dv_s11, dv_s12, dv_s13;
	logic [63:0]        n0_s11;
	logic signed [42:0] hb_s11;
	esc_pkg::mul_pp_t   ppn_s12, ppv_s12;
	logic [63:0]        num_s13, hv_s13, hv_s14, hv_s15, hv_s16, hv_s17;
	logic [63:0]        mag_s14;
	logic [30:0]        mb_s14;
	logic               neg_s14, dz_s14;
	esc_pkg::mul_pp_t   ppd_s14;
	logic [63:0]        hdd_s15;
	esc_pkg::mul_pp_t   ppk_s16;
	logic [63:0]        kk_s17, hv2_s18;
	esc_pkg::div_st_t   div_q [esc_pkg::DIV_STAGES];
	esc_pkg::side_t     side_q [esc_pkg::DIV_STAGES];
	logic [63:0]        p_s31, p_s32, p_s33, p_s34, p_s35;
	logic               dz_s31, dz_s32, dz_s33, dz_s34, dz_s35, dz_s36, dz_s37;
	esc_pkg::side_t     sd_s31, sd_s32, sd_s33, sd_s34, sd_s35, sd_s36, sd_s37;
	esc_pkg::mul_pp_t   ppx_s32, ppb_s32, ppa_s34;
	logic [63:0]        d_s32, d_s33, x_s33, b8_s33, b8_s34, b8_s35, a9_s35;
	logic [63:0]        ps_s36, q2_s37;

	// combinational helpers
	logic signed [21:0] e_c;
	logic signed [27:0] t5_c;
	logic signed [19:0] tc_c;
	logic [15:0]        tsat_c;
	logic signed [38:0] hnum_c;
	logic [20:0]        pr_c;
	logic [63:0]        q_c, hd_c, pd_c, q3_c, hcl_c;
	logic [16:0]        hout_c, pout_c;

	assign e_c  = 22'(dd_s2 >>> 12);
	assign t5_c = tf_s4 * 28'sd5 + 28'sd128;
	assign tc_c = 20'(t5_c >>> 8);

	// temperature saturation to 16 bits
	always_comb begin
		if (tc_c > 20'sd32767)
			tsat_c = 16'h7FFF;
		else if (tc_c < -20'sd32768)
			tsat_c = 16'h8000;
		else
			tsat_c = tc_c[15:0];
	end

	assign hnum_c = $signed({9'b0, rh_s6, 14'b0}) - $signed({h4, 20'b0}) - m5_s6
		+ 39'sd16384;
	assign pr_c   = 21'h100000 - {1'b0, rp_s10};
	assign hd_c   = 64'($signed(hv_s13) >>> 15);
	assign q_c    = div_q[esc_pkg::DIV_STAGES-1].dq;
	assign pd_c   = 64'($signed(p_s31) >>> 13);

	// humidity clamp to 0..419430400, then back to 1/1024 %
	always_comb begin
		if (hv2_s18[63])
			hcl_c = '0;
		else if (hv2_s18 > esc_pkg::HUM_MAX)
			hcl_c = esc_pkg::HUM_MAX;
		else
			hcl_c = hv2_s18;
		hout_c = hcl_c[28:12];
	end

	// final pressure shift and clamp; zero divisor gives zero
	always_comb begin
		q3_c = 64'($signed(q2_s37) >>> 8);
		if (dz_s37 || q3_c[63])
			pout_c = '0;
		else if (q3_c > 64'(esc_pkg::PRES_MAX))
			pout_c = esc_pkg::PRES_MAX;
		else
			pout_c = q3_c[16:0];
	end

	// front pipeline: fine temperature, polynomial terms, humidity terms, divider operands
	always_ff @(posedge clk) begin
		if (en) begin
			// s1: differences
			x1_s1  <= $signed({1'b0, rt[19:3]}) - $signed({1'b0, t1, 1'b0});
			d_s1   <= $signed({1'b0, rt[19:4]}) - $signed({1'b0, t1});
			rp_s1  <= rp;
			rh_s1  <= rh;
			// s2: first temperature products
			ma_s2  <= x1_s1 * t2;
			dd_s2  <= d_s1 * d_s1;
			rp_s2  <= rp_s1;
			rh_s2  <= rh_s1;
			// s3
			at_s3  <= 23'(ma_s2 >>> 11);
			eb_s3  <= e_c * t3;
			rp_s3  <= rp_s2;
			rh_s3  <= rh_s2;
			// s4: fine temperature
			tf_s4  <= at_s3 + 25'(eb_s3 >>> 14);
			rp_s4  <= rp_s3;
			rh_s4  <= rh_s3;
			// s5: temperature result and offsets for the other formulas
			tout_s5 <= tsat_c;
			pa_s5   <= tf_s4 - 26'sd128000;
			hv_s5   <= tf_s4 - 26'sd76800;
			rp_s5   <= rp_s4;
			rh_s5   <= rh_s4;
			// s6
			aa_s6   <= pa_s5 * pa_s5;
			ap5_s6  <= pa_s5 * p5;
			ap2_s6  <= pa_s5 * p2;
			m5_s6   <= h5 * hv_s5;
			m6_s6   <= hv_s5 * h6;
			m3_s6   <= hv_s5 * $signed({1'b0, h3});
			tout_s6 <= tout_s5;
			rp_s6   <= rp_s5;
			rh_s6   <= rh_s5;
			// s7: wrapping square terms
			pp6_s7  <= esc_pkg::mul_pp(64'(aa_s6), 64'(p6));
			pp3_s7  <= esc_pkg::mul_pp(64'(aa_s6), 64'(p3));
			ha_s7   <= 24'(hnum_c >>> 15);
			u_s7    <= 24'(m6_s6 >>> 10);
			w_s7    <= 25'(m3_s6 >>> 11) + 25'sd32768;
			ap5_s7  <= ap5_s6;
			ap2_s7  <= ap2_s6;
			tout_s7 <= tout_s6;
			rp_s7   <= rp_s6;
			// s8
			b6_s8   <= esc_pkg::mul_fin(pp6_s7);
			b3_s8   <= esc_pkg::mul_fin(pp3_s7);
			uw_s8   <= u_s7 * w_s7;
			ap5_s8  <= ap5_s7;
			ap2_s8  <= ap2_s7;
			ha_s8   <= ha_s7;
			tout_s8 <= tout_s7;
			rp_s8   <= rp_s7;
			// s9: pressure polynomial sums
			b_s9    <= b6_s8 + (64'(ap5_s8) << 17) + (64'(p4) << 35);
			ac_s9   <= 64'($signed(b3_s8) >>> 8) + (64'(ap2_s8) << 12)
				+ 64'h0000_8000_0000_0000;
			hb0_s9  <= 40'(uw_s8 >>> 10) + 40'sd2097152;
			ha_s9   <= ha_s8;
			tout_s9 <= tout_s8;
			rp_s9   <= rp_s8;
			// s10
			ppc_s10  <= esc_pkg::mul_pp(ac_s9, {48'b0, p1});
			m2_s10   <= hb0_s9 * h2;
			b_s10    <= b_s9;
			ha_s10   <= ha_s9;
			tout_s10 <= tout_s9;
			rp_s10   <= rp_s9;
			// s11: divisor and dividend base
			dv_s11   <= 31'($signed(esc_pkg::mul_fin(ppc_s10)) >>> 33);
			n0_s11   <= {12'b0, pr_c, 31'b0} - b_s10;
			hb_s11   <= 43'((m2_s10 + 56'sd8192) >>> 14);
			ha_s11   <= ha_s10;
			tout_s11 <= tout_s10;
			// s12
			ppn_s12  <= esc_pkg::mul_pp(n0_s11, 64'd3125);
			ppv_s12  <= esc_pkg::mul_pp(64'(ha_s11), 64'(hb_s11));
			dv_s12   <= dv_s11;
			tout_s12 <= tout_s11;
			// s13
			num_s13  <= esc_pkg::mul_fin(ppn_s12);
			hv_s13   <= esc_pkg::mul_fin(ppv_s12);
			dv_s13   <= dv_s12;
			tout_s13 <= tout_s12;
			// s14: magnitudes for the divider
			mag_s14  <= num_s13[63] ? -num_s13 : num_s13;
			mb_s14   <= dv_s13[30] ? 31'(-dv_s13) : dv_s13;
			neg_s14  <= num_s13[63] ^ dv_s13[30];
			dz_s14   <= (dv_s13 == '0);
			ppd_s14  <= esc_pkg::mul_pp(hd_c, hd_c);
			hv_s14   <= hv_s13;
			tout_s14 <= tout_s13;
			// s15..s18: humidity correction beside the divider
			hdd_s15  <= esc_pkg::mul_fin(ppd_s14);
			hv_s15   <= hv_s14;
			ppk_s16  <= esc_pkg::mul_pp(64'($signed(hdd_s15) >>> 7), {56'b0, h1});
			hv_s16   <= hv_s15;
			kk_s17   <= esc_pkg::mul_fin(ppk_s16);
			hv_s17   <= hv_s16;
			hv2_s18  <= hv_s17 - 64'($signed(kk_s17) >>> 4);
		end
	end

	// divider: 16 stages, 4 quotient bits each
	for (genvar k = 0; k < esc_pkg::DIV_STAGES; k++) begin : g_div
		esc_pkg::div_st_t din;
		esc_pkg::side_t   side_in;
		if (k == 0) begin : g_first
			assign din = '{rem: '0, dq: mag_s14, mb: mb_s14, neg: neg_s14, dz: dz_s14};
			assign side_in = '{tout: tout_s14, hout: '0};
		end else begin : g_next
			assign din = div_q[k-1];
			assign side_in = side_q[k-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				div_q[k] <= esc_pkg::div_steps(din);
				if (k == 4)
					side_q[k] <= '{tout: side_in.tout, hout: hout_c};
				else
					side_q[k] <= side_in;
			end
		end
	end

	// back pipeline: signed quotient and second-order pressure terms
	always_ff @(posedge clk) begin
		if (en) begin
			// s31
			p_s31   <= div_q[esc_pkg::DIV_STAGES-1].neg ? -q_c : q_c;
			dz_s31  <= div_q[esc_pkg::DIV_STAGES-1].dz;
			sd_s31  <= side_q[esc_pkg::DIV_STAGES-1];
			// s32
			ppx_s32 <= esc_pkg::mul_pp(64'(p9), pd_c);
			ppb_s32 <= esc_pkg::mul_pp(64'(p8), p_s31);
			d_s32   <= pd_c;
			p_s32   <= p_s31;
			dz_s32  <= dz_s31;
			sd_s32  <= sd_s31;
			// s33
			x_s33   <= esc_pkg::mul_fin(ppx_s32);
			b8_s33  <= 64'($signed(esc_pkg::mul_fin(ppb_s32)) >>> 19);
			d_s33   <= d_s32;
			p_s33   <= p_s32;
			dz_s33  <= dz_s32;
			sd_s33  <= sd_s32;
			// s34
			ppa_s34 <= esc_pkg::mul_pp(x_s33, d_s33);
			b8_s34  <= b8_s33;
			p_s34   <= p_s33;
			dz_s34  <= dz_s33;
			sd_s34  <= sd_s33;
			// s35
			a9_s35  <= 64'($signed(esc_pkg::mul_fin(ppa_s34)) >>> 25);
			b8_s35  <= b8_s34;
			p_s35   <= p_s34;
			dz_s35  <= dz_s34;
			sd_s35  <= sd_s34;
			// s36
			ps_s36  <= p_s35 + a9_s35 + b8_s35;
			dz_s36  <= dz_s35;
			sd_s36  <= sd_s35;
			// s37
			q2_s37  <= 64'($signed(ps_s36) >>> 8) + (64'(p7) << 4);
			dz_s37  <= dz_s36;
			sd_s37  <= sd_s36;
		end
	end

	// output register and skid stage
	logic [55:0] res_c, out_q, skd_q;
	assign res_c = {6'b0, sd_s37.hout, pout_c, sd_s37.tout};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sk_q <= 1'b0;
		end else if (sk_q) begin
			if (m_tready)
				sk_q <= 1'b0;
		end else if (vld_q[LAST]) begin
			if (ov_q && !m_tready)
				sk_q <= 1'b1;
			else
				ov_q <= 1'b1;
		end else if (m_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_q) begin
			if (m_tready)
				out_q <= skd_q;
		end else if (vld_q[LAST]) begin
			if (ov_q && !m_tready)
				skd_q <= res_c;
			else
				out_q <= res_c;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = out_q;

	// checks
	a_skid_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_q |-> ov_q) else $error("skid word held without an output word");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_q) |-> $past(ov_q && !m_tready && vld_q[LAST]))
		else $error("skid filled without a stalled output");

	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(ov_q) |-> $past(m_tready && !vld_q[LAST]))
		else $error("output word dropped without being taken");

endmodule
